// ===== rtl/pfpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel format palette converter package
// Shared types, codes, constants and channel expansion functions.
// ----------------------------------------------------------------------------
package pfpc_pkg;

  localparam int PaletteDepthDefault = 256;
  localparam int ColorW = 32;
  localparam int CountW = 9;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic ACT_CONVERT = 1'b0;
  localparam logic ACT_WRITE   = 1'b1;

  localparam logic [CountW-1:0] NEED_IDX8 = 9'd256;
  localparam logic [CountW-1:0] NEED_IDX4 = 9'd16;
  localparam logic [CountW-1:0] NEED_IDX1 = 9'd2;

  typedef enum logic [2:0] {
    MODE_XRGB32 = 3'd0,
    MODE_RGB24  = 3'd1,
    MODE_RGB565 = 3'd2,
    MODE_RGB332 = 3'd3,
    MODE_IDX8   = 3'd4,
    MODE_IDX4   = 3'd5,
    MODE_IDX1   = 3'd6,
    MODE_UNSUP  = 3'd7
  } pfpc_mode_t;

  typedef enum logic {
    REG_MODE   = 1'b0,
    REG_COLORS = 1'b1
  } pfpc_reg_t;

  typedef struct packed {
    pfpc_mode_t        mode;
    logic [CountW-1:0] colors;
  } pfpc_cfg_t;

  typedef struct packed {
    logic              action;
    logic [ColorW-1:0] source_bits;
    logic [2:0]        sub_position;
    logic [7:0]        entry_index;
    logic [ColorW-1:0] entry_color;
  } pfpc_in_t;

  typedef struct packed {
    logic [ColorW-1:0] pixel_color;
    logic              mode_error;
  } pfpc_out_t;

  // floor(v * 255 / 31) = 8v + floor(7v / 31); 7v / 31 by reciprocal 265 / 2^13
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0]  y;
    logic [16:0] p;
    y = 8'(v) * 8'd7;
    p = 17'(y) * 17'd265;
    return {v, 3'b000} + 8'(p >> 13);
  endfunction

  // floor(v * 255 / 63) = 4v + floor(v / 21)
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [1:0] q;
    q = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
    return {v, 2'b00} + 8'(q);
  endfunction

  function automatic logic [7:0] expand3(input logic [2:0] v);
    logic [7:0] r;
    unique case (v)
      3'd0: r = 8'd0;
      3'd1: r = 8'd36;
      3'd2: r = 8'd72;
      3'd3: r = 8'd109;
      3'd4: r = 8'd145;
      3'd5: r = 8'd182;
      3'd6: r = 8'd218;
      default: r = 8'd255;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] expand2(input logic [1:0] v);
    return {v, v, v, v};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pfpc_apb_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style access to the pixel mode and palette count registers.
// ----------------------------------------------------------------------------
module pfpc_apb_regs import pfpc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output pfpc_cfg_t                cfg
);

  pfpc_cfg_t regs;
  pfpc_reg_t sel;
  logic      wr;

  assign sel    = pfpc_reg_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode   <= MODE_XRGB32;
      regs.colors <= '0;
    end else if (wr) begin
      unique case (sel)
        REG_MODE:   regs.mode   <= pfpc_mode_t'(pwdata[2:0]);
        REG_COLORS: regs.colors <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_MODE:   prdata = ApbDataW'(regs.mode);
      REG_COLORS: prdata = ApbDataW'(regs.colors);
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/pfpc_palette_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Palette memory
// Synchronous palette store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pfpc_palette_ram import pfpc_pkg::*; #(
  parameter int PALETTE_DEPTH = PaletteDepthDefault,
  parameter int AW = $clog2(PALETTE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [ColorW-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [ColorW-1:0] rdata
);

  logic [ColorW-1:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pixel_format_palette_converter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel format palette converter
// Turns one pixel a cycle into XRGB32, palette included, unless rsp stalls.
// ----------------------------------------------------------------------------
// Requests enter on req (valid/ready). A convert request yields one result on
// rsp via the decode stage, which holds the palette memory read, and then the
// output register. A palette write request updates the palette memory at its
// accept edge and yields no result; a convert accepted in the next cycle
// already sees the new entry. One request is taken every cycle that req_ready
// is high; it uses either the palette memory write port or its read port.
// When rsp stalls, the decode stage and the output register fill and req_ready
// falls once both hold a result; nothing is lost or repeated.
// Reset clears the mode and palette count registers and empties the pipeline;
// palette contents are undefined until written.
// The configuration port holds pixel_mode at byte address 0 and
// palette_colors at byte address 4; pready is always high.
// ----------------------------------------------------------------------------
module pixel_format_palette_converter_unit import pfpc_pkg::*; #(
  parameter int PALETTE_DEPTH = PaletteDepthDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire pfpc_in_t            req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output pfpc_out_t                rsp,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [CountW-1:0] DepthW = CountW'(PALETTE_DEPTH);

  pfpc_cfg_t cfg;

  logic              req_accept;
  logic              is_convert;
  logic              mem_we;
  logic [7:0]        b0;
  logic [7:0]        index;
  logic              lookup;
  logic              err;
  logic [ColorW-1:0] color;
  logic [ColorW-1:0] rd_data;

  logic              s1_valid;
  logic              s1_lookup;
  logic              s1_err;
  logic [ColorW-1:0] s1_color;
  logic              s1_move;

  pfpc_out_t         rsp_q;
  logic              rsp_valid_q;

  pfpc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_move    = s1_valid && (!rsp_valid_q || rsp_ready);
  assign req_ready  = !s1_valid || s1_move;
  assign req_accept = req_valid && req_ready;
  assign is_convert = (req.action == ACT_CONVERT);
  assign mem_we     = req_accept && (req.action == ACT_WRITE)
                      && ({1'b0, req.entry_index} < DepthW);
  assign b0         = req.source_bits[7:0];

  always_comb begin
    index  = '0;
    lookup = 1'b0;
    err    = 1'b0;
    color  = '0;
    unique case (cfg.mode)
      MODE_XRGB32: color = req.source_bits;
      MODE_RGB24:  color = {8'h00, b0, req.source_bits[15:8], req.source_bits[23:16]};
      MODE_RGB565: color = {8'h00, expand5(req.source_bits[15:11]),
                            expand6(req.source_bits[10:5]), expand5(req.source_bits[4:0])};
      MODE_RGB332: color = {8'h00, expand3(b0[7:5]), expand3(b0[4:2]), expand2(b0[1:0])};
      MODE_IDX8: begin
        index  = b0;
        lookup = 1'b1;
        err    = (cfg.colors < NEED_IDX8) || ({1'b0, b0} >= DepthW);
      end
      MODE_IDX4: begin
        index  = {4'h0, req.sub_position[0] ? b0[7:4] : b0[3:0]};
        lookup = 1'b1;
        err    = (cfg.colors < NEED_IDX4);
      end
      MODE_IDX1: begin
        index  = {7'h00, b0[req.sub_position]};
        lookup = 1'b1;
        err    = (cfg.colors < NEED_IDX1);
      end
      default: err = 1'b1;
    endcase
  end

  pfpc_palette_ram #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .AW            (AW)
  ) u_palette (
    .clk   (clk),
    .we    (mem_we),
    .waddr (req.entry_index[AW-1:0]),
    .wdata (req.entry_color),
    .re    (req_accept && is_convert),
    .raddr (index[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_accept && is_convert) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept && is_convert) begin
      s1_lookup <= lookup && !err;
      s1_err    <= err;
      s1_color  <= color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (s1_move) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp_q.mode_error  <= s1_err;
      rsp_q.pixel_color <= s1_err ? '0 : (s1_lookup ? rd_data : s1_color);
    end
  end

  assign rsp_valid = rsp_valid_q;
  assign rsp       = rsp_q;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.mode_error |-> rsp.pixel_color == '0)
    else $error("error result carries a non-zero colour");

  a_unsup_err: assert property (@(posedge clk) disable iff (rst)
    req_accept && is_convert && cfg.mode == MODE_UNSUP |=> s1_valid && s1_err)
    else $error("unsupported mode did not flag an error");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    req_accept && !is_convert && !s1_valid |=> !s1_valid)
    else $error("palette write produced a result");

endmodule
`default_nettype wire

// ===== tb/sv/pfpc_colour_checker.sv =====
// ----------------------------------------------------------------------------
// Pixel format palette converter colour checker
// Watches the request, result and register ports, predicts each converted
// colour from its own copy of the mode, palette count and palette, and
// compares every result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module pfpc_colour_checker import pfpc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  pfpc_in_t            req,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  pfpc_out_t           rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output int                  fail_count,
  output int                  pending,
  output int                  results_checked
);

  pfpc_out_t         expected_colours[$];
  logic [ColorW-1:0] palette_shadow[PaletteDepthDefault];
  pfpc_mode_t        cur_mode;
  logic [CountW-1:0] cur_colors;

  initial begin
    fail_count = 0;
    pending = 0;
    results_checked = 0;
    cur_mode = MODE_XRGB32;
    cur_colors = '0;
  end

  function automatic logic [7:0] widen(int v, int top);
    return 8'((v * 255) / top);
  endfunction

  function automatic pfpc_out_t predict_colour(pfpc_in_t r);
    pfpc_out_t         o;
    logic [7:0]        b0;
    logic [ColorW-1:0] colour;
    logic [CountW-1:0] need;
    logic              ok;
    int                idx;
    b0 = r.source_bits[7:0];
    colour = '0;
    need = '0;
    ok = 1'b1;
    idx = 0;
    case (cur_mode)
      MODE_XRGB32: colour = r.source_bits;
      MODE_RGB24: colour = {8'h00, b0, r.source_bits[15:8], r.source_bits[23:16]};
      MODE_RGB565: colour = {8'h00, widen(r.source_bits[15:11], 31),
                             widen(r.source_bits[10:5], 63), widen(r.source_bits[4:0], 31)};
      MODE_RGB332: colour = {8'h00, widen(b0[7:5], 7), widen(b0[4:2], 7), widen(b0[1:0], 3)};
      MODE_IDX8: begin
        need = NEED_IDX8;
        idx = b0;
      end
      MODE_IDX4: begin
        need = NEED_IDX4;
        idx = r.sub_position[0] ? b0[7:4] : b0[3:0];
      end
      MODE_IDX1: begin
        need = NEED_IDX1;
        idx = b0[r.sub_position];
      end
      default: ok = 1'b0;
    endcase
    if (need != '0) begin
      if (cur_colors < need) ok = 1'b0;
      else colour = palette_shadow[idx];
    end
    o.pixel_color = ok ? colour : '0;
    o.mode_error = !ok;
    return o;
  endfunction

  always @(posedge clk) begin
    pfpc_out_t want;
    if (rst) begin
      expected_colours.delete();
      cur_mode = MODE_XRGB32;
      cur_colors = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (pfpc_reg_t'(paddr[ApbAddrW-1:2]))
          REG_MODE:   cur_mode = pfpc_mode_t'(pwdata[2:0]);
          REG_COLORS: cur_colors = pwdata[CountW-1:0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        results_checked++;
        if (expected_colours.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: colour %08h error %0b", rsp.pixel_color, rsp.mode_error);
        end else begin
          want = expected_colours.pop_front();
          if (rsp.pixel_color !== want.pixel_color || rsp.mode_error !== want.mode_error) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: colour exp %08h got %08h, error exp %0b got %0b",
                       want.pixel_color, rsp.pixel_color, want.mode_error, rsp.mode_error);
          end
        end
      end
      if (req_valid && req_ready) begin
        if (req.action == ACT_WRITE) palette_shadow[req.entry_index] = req.entry_color;
        else expected_colours.push_back(predict_colour(req));
      end
    end
    pending = expected_colours.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Pixel format palette converter testbench
// Fills the palette, runs directed conversions through every mode and the
// palette-count and error corners, then random phases of convert and palette
// write requests under random idling on both channels, a long result stall
// and a quiet tail. The colour checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import pfpc_pkg::*;

  logic                clk;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  pfpc_in_t            req = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  pfpc_out_t           rsp;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int fail_count;
  int pending;
  int results_checked;
  int converts = 0;
  int writes = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  bit hold_active = 1'b0;

  pixel_format_palette_converter_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pfpc_colour_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending), .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        stall_left = 80;
        hold_active = 1'b1;
      end
      if (quiet) begin
        hold_active = 1'b0;
        rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        hold_active = 1'b0;
        if (run_left > 0) begin
          rsp_ready <= 1'b1;
          run_left--;
        end else if ($urandom_range(0, 2) == 0) begin
          stall_left = $urandom_range(1, 14) - 1;
          rsp_ready <= 1'b0;
        end else begin
          run_left = $urandom_range(1, 24) - 1;
          rsp_ready <= 1'b1;
        end
      end
    end
  end

  function automatic pfpc_in_t make_request(logic act, logic [31:0] src, logic [2:0] pos,
                                             logic [7:0] idx, logic [31:0] col);
    pfpc_in_t r;
    r.action = act;
    r.source_bits = src;
    r.sub_position = pos;
    r.entry_index = idx;
    r.entry_color = col;
    return r;
  endfunction

  task automatic push_request(pfpc_in_t r);
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (r.action == ACT_WRITE) writes++;
    else converts++;
    if (!quiet && !hold_active && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic convert(logic [31:0] src, logic [2:0] pos);
    push_request(make_request(ACT_CONVERT, src, pos, 8'($urandom_range(0, 255)), $urandom()));
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
      waited++;
      if (waited > 5000) begin
        $display("FAILURE");
        $finish;
      end
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(pfpc_reg_t which, logic [ApbDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ApbAddrW'({which, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(pfpc_mode_t mode, int colours);
    drain();
    set_register(REG_MODE, ApbDataW'(mode));
    set_register(REG_COLORS, ApbDataW'(colours));
  endtask

  initial begin
    pfpc_mode_t mode;
    int colours;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    convert(32'h0000_0000, 3'd0);
    convert(32'hffff_ffff, 3'd7);
    for (int i = 0; i < PaletteDepthDefault; i++)
      push_request(make_request(ACT_WRITE, $urandom(), 3'($urandom_range(0, 7)), 8'(i),
                                $urandom()));

    configure(MODE_RGB24, 0);
    convert(32'h00a1_b2c3, 3'd0);
    convert(32'hffff_ffff, 3'd0);
    configure(MODE_RGB565, 0);
    convert(32'h0000_ffff, 3'd0);
    convert(32'hffff_0000, 3'd0);
    convert(32'h0000_f800, 3'd0);
    convert(32'h0000_07e0, 3'd0);
    convert(32'h0000_001f, 3'd0);
    configure(MODE_RGB332, 0);
    convert(32'hffff_ffe0, 3'd0);
    convert(32'h0000_001c, 3'd0);
    convert(32'h0000_0003, 3'd0);
    convert(32'h0000_00ff, 3'd0);
    configure(MODE_IDX8, 255);
    convert(32'h0000_00ff, 3'd0);
    configure(MODE_IDX8, 256);
    push_request(make_request(ACT_WRITE, 32'h0, 3'd0, 8'ha5, 32'hdead_beef));
    convert(32'h0000_00a5, 3'd0);
    convert(32'h0000_0000, 3'd0);
    configure(MODE_IDX4, 15);
    convert(32'h0000_005c, 3'd0);
    configure(MODE_IDX4, 16);
    convert(32'h0000_005c, 3'd0);
    convert(32'h0000_005c, 3'd1);
    convert(32'h0000_005c, 3'd7);
    configure(MODE_IDX1, 1);
    convert(32'h0000_0081, 3'd0);
    configure(MODE_IDX1, 2);
    convert(32'h0000_0081, 3'd0);
    convert(32'h0000_0081, 3'd7);
    convert(32'h0000_0081, 3'd3);
    configure(MODE_UNSUP, 256);
    convert(32'h1234_5678, 3'd0);

    for (int p = 0; p < 16; p++) begin
      mode = pfpc_mode_t'(p % 8);
      case ($urandom_range(0, 5))
        0: colours = 0;
        1: colours = $urandom_range(0, 256);
        default: colours = 256;
      endcase
      configure(mode, colours);
      if (p == 5) long_hold = 1'b1;
      if (p == 14) quiet = 1'b1;
      for (int n = 0; n < 32; n++)
        push_request(make_request($urandom_range(0, 99) < 20 ? ACT_WRITE : ACT_CONVERT,
                                  $urandom(), 3'($urandom_range(0, 7)),
                                  8'($urandom_range(0, 255)), $urandom()));
    end
    drain();

    $display("Covered %0d conversions and %0d palette writes across all eight modes,",
             converts, writes);
    $display("including palette count corners and stalls; %0d results checked.",
             results_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pfpc_pkg.sv
rtl/pfpc_apb_regs.sv
rtl/pfpc_palette_ram.sv
rtl/pixel_format_palette_converter_unit.sv
tb/sv/pfpc_colour_checker.sv
tb/sv/tb_top.sv
